[rtl/core/srs_pkg.sv]
`default_nettype none

package srs_pkg;

  localparam int unsigned TicksW    = 14;
  localparam int unsigned CoolW     = 13;
  localparam int unsigned RangeW    = 9;
  localparam int unsigned WaitLimW  = 8;
  localparam int unsigned WidthLimW = 10;
  localparam int unsigned PeriodW   = 6;
  localparam int unsigned StepW     = 4;
  localparam int unsigned LevelW    = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned EchoW     = 3;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 48;

  typedef enum logic [4:0] {
    PH_STANDBY  = 5'b00001,
    PH_TRIGGER  = 5'b00010,
    PH_WAIT     = 5'b00100,
    PH_MEASURE  = 5'b01000,
    PH_COOLDOWN = 5'b10000
  } ph_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WAIT_LIM  = 2'd0,
    CFG_WIDTH_LIM = 2'd1,
    CFG_PERIOD    = 2'd2,
    CFG_STEP      = 2'd3
  } cfg_idx_e;

  // what one channel lane reports to the merge logic after a tick
  typedef struct packed {
    logic              idle;
    logic              fired;
    logic [RangeW-1:0] rng;
  } lane_stat_t;

endpackage

`default_nettype wire

[rtl/core/srs_chan.sv]
`default_nettype none

module srs_chan (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire logic                             echo_i,
  input  wire logic                             start_i,
  input  wire logic [srs_pkg::WaitLimW-1:0]     wait_lim_i,
  input  wire logic [srs_pkg::WidthLimW-1:0]    width_lim_i,
  output srs_pkg::lane_stat_t                   stat_o
);

  srs_pkg::ph_e                   ph_q, ph_step, ph_d;
  logic [srs_pkg::TicksW-1:0]     ticks_q, ticks_d, t_inc, width;
  logic [srs_pkg::CoolW-1:0]      cool_q, cool_d;
  logic [srs_pkg::RangeW-1:0]     rng_q, rng_d;
  logic [srs_pkg::TicksW-1:0]     cool_sum;
  logic                           fin, fin_ok, fired;

  assign t_inc    = ticks_q + 14'd1;
  // width never exceeds 1024, so eight times it fits beside the old average
  assign cool_sum = {1'b0, cool_q} + {width[10:0], 3'b000};

  always_comb begin
    ph_step = ph_q;
    ticks_d = ticks_q;
    fin     = 1'b0;
    fin_ok  = 1'b0;
    width   = ticks_q;
    fired   = 1'b0;
    case (ph_q)
      srs_pkg::PH_STANDBY: begin
        ph_step = srs_pkg::PH_STANDBY;
      end
      srs_pkg::PH_TRIGGER: begin
        ph_step = srs_pkg::PH_WAIT;
        fired   = 1'b1;
      end
      srs_pkg::PH_WAIT: begin
        if (echo_i || (t_inc > {6'd0, wait_lim_i})) begin
          ticks_d = 14'd1;
          ph_step = srs_pkg::PH_MEASURE;
        end else begin
          ticks_d = t_inc;
        end
      end
      srs_pkg::PH_MEASURE: begin
        if (echo_i) begin
          if (t_inc > {4'd0, width_lim_i}) begin
            fin   = 1'b1;
            width = t_inc;
          end else begin
            ticks_d = t_inc;
          end
        end else begin
          fin    = 1'b1;
          fin_ok = 1'b1;
        end
      end
      srs_pkg::PH_COOLDOWN: begin
        if (t_inc > {1'b0, cool_q}) begin
          ticks_d = '0;
          ph_step = srs_pkg::PH_STANDBY;
        end else begin
          ticks_d = t_inc;
        end
      end
      default: begin
        ph_step = srs_pkg::PH_STANDBY;
      end
    endcase
    if (fin) begin
      ticks_d = '0;
      ph_step = srs_pkg::PH_COOLDOWN;
    end
  end

  assign cool_d = fin ? cool_sum[srs_pkg::TicksW-1:1] : cool_q;
  assign rng_d  = fin ? (fin_ok ? width[9:1] : '0) : rng_q;
  assign ph_d   = start_i ? srs_pkg::PH_TRIGGER : ph_step;

  assign stat_o.idle  = (ph_step == srs_pkg::PH_STANDBY);
  assign stat_o.fired = fired;
  assign stat_o.rng   = rng_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= srs_pkg::PH_STANDBY;
      ticks_q <= '0;
      cool_q  <= '0;
      rng_q   <= '0;
    end else if (en_i) begin
      ph_q    <= ph_d;
      ticks_q <= ticks_d;
      cool_q  <= cool_d;
      rng_q   <= rng_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/srs_drive.sv]
`default_nettype none

module srs_drive (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         strobe_i,
  input  wire logic [srs_pkg::LevelW-1:0]   target_i,
  input  wire logic [srs_pkg::StepW-1:0]    step_i,
  output logic      [srs_pkg::LevelW-1:0]   level_o
);

  logic [srs_pkg::LevelW-1:0] lvl_q, lvl_step;
  logic [srs_pkg::LevelW:0]   sum;

  assign sum = {1'b0, lvl_q} + {5'd0, step_i};

  always_comb begin
    lvl_step = lvl_q;
    if (lvl_q < target_i) begin
      lvl_step = sum[srs_pkg::LevelW] ? 8'hFF : sum[srs_pkg::LevelW-1:0];
    end else if (lvl_q > target_i) begin
      lvl_step = (lvl_q > {4'd0, step_i}) ? (lvl_q - {4'd0, step_i}) : '0;
    end
  end

  assign level_o = strobe_i ? lvl_step : lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= '0;
    end else if (en_i && strobe_i) begin
      lvl_q <= lvl_step;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sonar_ranging_sequencer.sv]
// Sonar ranging sequencer: one input word is one timer tick, carrying the echo
// levels of three ultrasonic channels and the left/right drive targets. Each
// word produces exactly one output word with the trigger pulses, the latest
// range of every channel and the ramped drive levels. A word is taken every
// clock while the output side keeps up; its result appears in the output
// register in the next cycle, and a new word is accepted in the same cycle the
// previous result is taken. All channel lanes and drive lanes update in that
// single cycle, so the rate is one word per clock, set by the output register
// handshake alone. There is no start-up clearing pass. Configuration writes
// should only happen while no word is in flight.
`default_nettype none

module sonar_ranging_sequencer #(
  parameter int unsigned NUM_CHANNELS = 3,
  parameter int unsigned NUM_DRIVES   = 2
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // echo_mask[2:0], target_left[10:3], target_right[18:11]
  input  wire logic [srs_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // trigger_mask[2:0], range_a[11:3], range_b[20:12], range_c[29:21],
  // drive_left[37:30], drive_right[45:38], drive_strobe[46]
  output logic      [srs_pkg::OutDataW-1:0]   m_axis_tdata,
  input  wire logic                           cfg_we_i,
  input  wire logic [srs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [srs_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  localparam int unsigned NextW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic                              accept;
  logic [srs_pkg::EchoW-1:0]         echo_mask;
  logic [srs_pkg::LevelW-1:0]        tgt_left, tgt_right;

  logic [srs_pkg::WaitLimW-1:0]      wait_lim_q;
  logic [srs_pkg::WidthLimW-1:0]     width_lim_q;
  logic [srs_pkg::PeriodW-1:0]       period_q, ramp_cnt_q, ramp_cnt_d, ramp_inc;
  logic [srs_pkg::StepW-1:0]         step_q;
  logic [NextW-1:0]                  next_q, next_d, sel;
  logic                              strobe, all_idle;

  srs_pkg::lane_stat_t               stat [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]           idle_vec, start_vec;
  logic [srs_pkg::EchoW-1:0]         trig;
  logic [srs_pkg::RangeW-1:0]        rng_out [3];
  logic [srs_pkg::LevelW-1:0]        lvl_out [2];
  logic [srs_pkg::LevelW-1:0]        lvl     [NUM_DRIVES];

  logic                              out_valid_q;
  logic [srs_pkg::OutDataW-1:0]      out_data_q, out_data_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign echo_mask     = s_axis_tdata[2:0];
  assign tgt_left      = s_axis_tdata[10:3];
  assign tgt_right     = s_axis_tdata[18:11];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_lim_q  <= 8'd16;
      width_lim_q <= 10'd800;
      period_q    <= 6'd20;
      step_q      <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srs_pkg::CFG_WAIT_LIM:  wait_lim_q  <= cfg_wdata_i[srs_pkg::WaitLimW-1:0];
        srs_pkg::CFG_WIDTH_LIM: width_lim_q <= cfg_wdata_i;
        srs_pkg::CFG_PERIOD:    period_q    <= cfg_wdata_i[srs_pkg::PeriodW-1:0];
        srs_pkg::CFG_STEP:      step_q      <= cfg_wdata_i[srs_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  // channel lanes
  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
    logic echo;
    if (i < srs_pkg::EchoW) begin : g_echo
      assign echo = echo_mask[i];
    end else begin : g_no_echo
      assign echo = 1'b0;
    end
    assign idle_vec[i]  = stat[i].idle;
    assign start_vec[i] = all_idle && (sel == NextW'(i));

    srs_chan u_chan (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (accept),
      .echo_i      (echo),
      .start_i     (start_vec[i]),
      .wait_lim_i  (wait_lim_q),
      .width_lim_i (width_lim_q),
      .stat_o      (stat[i])
    );
  end

  // merge: round-robin ping start once every lane has settled to standby
  assign all_idle = &idle_vec;
  assign sel      = ({1'b0, next_q} >= (NextW + 1)'(NUM_CHANNELS)) ? '0 : next_q;
  assign next_d   = (sel == NextW'(NUM_CHANNELS - 1)) ? '0 : sel + NextW'(1);

  for (genvar i = 0; i < 3; i++) begin : g_out_ch
    if (i < NUM_CHANNELS) begin : g_on
      assign trig[i]    = stat[i].fired;
      assign rng_out[i] = stat[i].rng;
    end else begin : g_off
      assign trig[i]    = 1'b0;
      assign rng_out[i] = '0;
    end
  end

  // ramp timing
  assign ramp_inc   = ramp_cnt_q + 6'd1;
  assign strobe     = (ramp_inc == period_q);
  assign ramp_cnt_d = strobe ? '0 : ramp_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q     <= '0;
      ramp_cnt_q <= '0;
    end else if (accept) begin
      if (all_idle) begin
        next_q <= next_d;
      end
      ramp_cnt_q <= ramp_cnt_d;
    end
  end

  // drive lanes
  for (genvar i = 0; i < NUM_DRIVES; i++) begin : g_drv
    logic [srs_pkg::LevelW-1:0] tgt;
    if (i == 0) begin : g_left
      assign tgt = tgt_left;
    end else if (i == 1) begin : g_right
      assign tgt = tgt_right;
    end else begin : g_zero
      assign tgt = '0;
    end

    srs_drive u_drive (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (accept),
      .strobe_i (strobe),
      .target_i (tgt),
      .step_i   (step_q),
      .level_o  (lvl[i])
    );
  end

  for (genvar i = 0; i < 2; i++) begin : g_out_drv
    if (i < NUM_DRIVES) begin : g_on
      assign lvl_out[i] = lvl[i];
    end else begin : g_off
      assign lvl_out[i] = '0;
    end
  end

  assign out_data_d = {1'b0, strobe, lvl_out[1], lvl_out[0],
                       rng_out[2], rng_out[1], rng_out[0], trig};

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

[rtl/core/srs_checker.sv]
`default_nettype none

module srs_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [srs_pkg::OutDataW-1:0]   m_axis_tdata
);

  // a stalled result word must hold
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // every accepted tick yields a result on the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted tick produced no result");

  // with the output register empty the input side must be open
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // only one channel is pinged at a time
  a_one_trigger: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[2:0]))
    else $error("more than one trigger in a word");

endmodule

bind sonar_ranging_sequencer srs_checker u_srs_checker (.*);

`default_nettype wire
